// ===== sv/cri_pkg.sv =====
`default_nettype none

package cri_pkg;

    localparam int MAX_STOPS_DEF = 32;

    localparam int CH_W    = 16;
    localparam int POS_W   = 16;
    localparam int FRAC_W  = 12;
    localparam int W_W     = FRAC_W + 1;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 4 * CH_W;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [W_W-1:0] ONE_Q12   = W_W'(4096);
    localparam logic [W_W-1:0] ZERO_Q12  = '0;
    localparam logic [13:0]    THREE_Q12 = 14'd12288;
    localparam logic signed [31:0] HALF_Q12 = 32'sd2048;

    localparam int DIV_STEPS = FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [2:0] MODE_LINEAR   = 3'd0;
    localparam logic [2:0] MODE_EASE     = 3'd1;
    localparam logic [2:0] MODE_CONST    = 3'd2;
    localparam logic [2:0] MODE_BSPLINE  = 3'd3;
    localparam logic [2:0] MODE_CARDINAL = 3'd4;

    localparam logic [1:0] COLOR_RGB = 2'd0;
    localparam logic [1:0] COLOR_HSV = 2'd1;
    localparam logic [1:0] COLOR_HSL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 2'd2;

    localparam logic [CFG_W-1:0] STOP_COUNT_RST = 6'd2;

    typedef struct packed {
        logic [CH_W-1:0]         alpha;
        logic [CH_W-1:0]         blue;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         red;
        logic signed [POS_W-1:0] pos;
    } stop_t;

    localparam int STOP_W = $bits(stop_t);

    typedef struct packed {
        logic              start;
        logic [POS_W-1:0]  num;
        logic [POS_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/cri_ram.sv =====
`default_nettype none

module cri_ram
    import cri_pkg::*;
#(
    parameter int WIDTH = STOP_W,
    parameter int DEPTH = MAX_STOPS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/cri_div.sv =====
`default_nettype none

module cri_div
    import cri_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0]     rem_reg;
    logic [POS_W-1:0]     den_reg;
    logic [FRAC_W-1:0]    quo_reg;

    logic [POS_W:0]       shifted;
    logic                 fits;
    logic [POS_W:0]       rem_next;

    // remainder stays below the divisor, so the doubled value fits one extra bit
    assign shifted  = {rem_reg, 1'b0};
    assign fits     = shifted >= {1'b0, den_reg};
    assign rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[POS_W-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ===== sv/color_ramp_interpolator.sv =====
// Evaluate item: accept, fetch stop 0, then per later stop a decide state, the
// 12-step shared divider when the weight is not clamped, EASE1 and EASE2 for easing,
// and the one-channel-per-cycle mix, then the output register, held while full.
// Items are taken one at a time, only in IDLE, once the last has reached the output
// register; load items and evaluations with a stop count of zero give no result.
// Reset (async, active low) restores register defaults; the stop store is undefined.
`default_nettype none

module color_ramp_interpolator
    import cri_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // stop_index[4:0], stop_position[20:5], stop_red[36:21], stop_green[52:37],
    // stop_blue[68:53], stop_alpha[84:69], factor[100:85], zero[103:101]
    input  wire logic [IN_W-1:0]      s_tdata,
    // operation[0]
    input  wire logic [0:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
    output logic [OUT_W-1:0]          m_tdata
);

    localparam int ADDR_W = $clog2(MAX_STOPS);
    localparam int CNT_W  = $clog2(MAX_STOPS + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_INIT  = 8'b0000_0010,
        ST_SEG   = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_EASE1 = 8'b0001_0000,
        ST_EASE2 = 8'b0010_0000,
        ST_MIX   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] count_reg;
    logic [2:0]       interp_reg;
    logic [1:0]       color_reg;

    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_inc;
    logic [1:0]       ch_reg;
    logic             step_mode_reg;
    logic             ease_mode_reg;

    logic signed [POS_W-1:0] fac_reg;
    logic signed [POS_W-1:0] prev_pos_reg;
    logic [W_W-1:0]          w_reg;
    logic [25:0]             sq_reg;
    logic [CH_W-1:0]         acc_reg [4];
    logic [CH_W-1:0]         cur_reg [4];

    logic            out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic             in_fire;
    logic             op;
    logic [4:0]       in_index;
    stop_t            in_stop;
    logic [CNT_W-1:0] n_sat;
    logic             out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    stop_t             ram_rdata;

    logic signed [POS_W-1:0] p1;
    logic signed [POS_W:0]   num_c;
    logic signed [POS_W:0]   den_c;
    logic                    seg_step;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [13:0]             ease_k;
    logic [39:0]             ease_t;
    logic signed [CH_W:0]    mix_diff;
    logic signed [30:0]      mix_prod;
    logic signed [31:0]      mix_sum;
    logic [CH_W-1:0]         mix_acc;

    // ---- input unpacking ----
    assign op            = s_tuser[0];
    assign in_index      = s_tdata[4:0];
    assign in_stop.pos   = s_tdata[20:5];
    assign in_stop.red   = s_tdata[36:21];
    assign in_stop.green = s_tdata[52:37];
    assign in_stop.blue  = s_tdata[68:53];
    assign in_stop.alpha = s_tdata[84:69];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign n_sat = (int'(count_reg) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(count_reg);

    // ---- stop store ----
    assign ram_we    = in_fire && (op == OP_LOAD) && (int'(in_index) < MAX_STOPS);
    assign ram_waddr = ADDR_W'(in_index);
    assign i_inc     = i_reg + CNT_W'(1);

    always_comb
    begin
        priority case (1'b1)
            (state_reg == ST_IDLE): ram_raddr = '0;
            (state_reg == ST_INIT): ram_raddr = i_reg[ADDR_W-1:0];
            default:                ram_raddr = i_inc[ADDR_W-1:0];
        endcase
    end

    cri_ram #(
        .WIDTH (STOP_W),
        .DEPTH (MAX_STOPS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_stop),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- segment decision ----
    assign p1       = $signed(ram_rdata.pos);
    assign num_c    = $signed({fac_reg[POS_W-1], fac_reg})
                    - $signed({prev_pos_reg[POS_W-1], prev_pos_reg});
    assign den_c    = $signed({p1[POS_W-1], p1})
                    - $signed({prev_pos_reg[POS_W-1], prev_pos_reg});
    assign seg_step = step_mode_reg || !(p1 > prev_pos_reg);

    assign div_req.start = (state_reg == ST_SEG) && !seg_step
                        && (num_c > 17'sd0) && (num_c < den_c);
    assign div_req.num   = num_c[POS_W-1:0];
    assign div_req.den   = den_c[POS_W-1:0];

    cri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---- ease and mix datapath ----
    assign ease_k   = THREE_Q12 - {w_reg, 1'b0};
    assign ease_t   = 40'(sq_reg) * 40'(ease_k);

    // acc*(1-w) + c*w folds into acc + (c - acc)*w, one multiply per channel
    assign mix_diff = $signed({1'b0, cur_reg[ch_reg]}) - $signed({1'b0, acc_reg[ch_reg]});
    assign mix_prod = 31'(mix_diff) * 31'($signed({1'b0, w_reg}));
    assign mix_sum  = $signed({4'b0, acc_reg[ch_reg], 12'b0}) + 32'(mix_prod) + HALF_Q12;
    assign mix_acc  = mix_sum[27:12];

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op == OP_EVAL) && (n_sat != '0))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = (n_reg == CNT_W'(1)) ? ST_DONE : ST_SEG;
            end
            ST_SEG:
            begin
                state_next = div_req.start ? ST_DIV : ST_MIX;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ease_mode_reg ? ST_EASE1 : ST_MIX;
                end
            end
            ST_EASE1:
            begin
                state_next = ST_EASE2;
            end
            ST_EASE2:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (ch_reg == 2'd3)
                begin
                    state_next = (i_inc < n_reg) ? ST_SEG : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= STOP_COUNT_RST;
            interp_reg    <= MODE_LINEAR;
            color_reg     <= COLOR_RGB;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STOP_COUNT:  count_reg  <= cfg_data;
                    REG_INTERP_MODE: interp_reg <= cfg_data[2:0];
                    REG_COLOR_MODE:  color_reg  <= cfg_data[1:0];
                    default:         ;
                endcase
            end
            if (state_reg == ST_MIX)
            begin
                ch_reg <= ch_reg + 2'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (op == OP_EVAL))
        begin
            fac_reg       <= $signed(s_tdata[100:85]);
            n_reg         <= n_sat;
            i_reg         <= CNT_W'(1);
            step_mode_reg <= (color_reg == COLOR_RGB) && (interp_reg == MODE_CONST);
            ease_mode_reg <= (color_reg == COLOR_RGB) && (interp_reg == MODE_EASE);
        end
        if (state_reg == ST_INIT)
        begin
            acc_reg[0]   <= ram_rdata.red;
            acc_reg[1]   <= ram_rdata.green;
            acc_reg[2]   <= ram_rdata.blue;
            acc_reg[3]   <= ram_rdata.alpha;
            prev_pos_reg <= p1;
        end
        if (state_reg == ST_SEG)
        begin
            cur_reg[0]   <= ram_rdata.red;
            cur_reg[1]   <= ram_rdata.green;
            cur_reg[2]   <= ram_rdata.blue;
            cur_reg[3]   <= ram_rdata.alpha;
            prev_pos_reg <= p1;
            // step and clamped weights skip the divider
            if (seg_step)
            begin
                w_reg <= (fac_reg >= p1) ? ONE_Q12 : ZERO_Q12;
            end
            else if (num_c <= 17'sd0)
            begin
                w_reg <= ZERO_Q12;
            end
            else if (num_c >= den_c)
            begin
                w_reg <= ONE_Q12;
            end
        end
        if ((state_reg == ST_DIV) && div_rsp.done)
        begin
            w_reg <= {1'b0, div_rsp.quo};
        end
        if (state_reg == ST_EASE1)
        begin
            sq_reg <= 26'(w_reg) * 26'(w_reg);
        end
        if (state_reg == ST_EASE2)
        begin
            w_reg <= ease_t[36:24];
        end
        if (state_reg == ST_MIX)
        begin
            acc_reg[ch_reg] <= mix_acc;
            if (ch_reg == 2'd3)
            begin
                i_reg <= i_inc;
            end
        end
        if (out_load)
        begin
            out_data_reg <= {acc_reg[3], acc_reg[2], acc_reg[1], acc_reg[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX) |-> (w_reg <= ONE_Q12))
        else $error("weight above one at mix");

    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG) |-> ((i_reg < n_reg) && (i_reg != '0)))
        else $error("segment index outside the stops in use");

    a_mix_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MIX) && (ch_reg != 2'd3)) |=> (state_reg == ST_MIX))
        else $error("mix left before all channels");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_color_ramp_interpolator.sv =====
`default_nettype none

module tb_color_ramp_interpolator
    import cri_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int QUIET_ITEMS   = 200;
    // longest evaluation plus margin
    localparam int SETTLE_CYCLES = 3 + 20 * (MAX_STOPS_DEF - 1) + 20;
    localparam int CYCLE_LIMIT   = 4_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [2:0] MODE_UNKNOWN  = 3'd7;
    localparam logic [1:0] COLOR_UNKNOWN = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;

    // shadow of the block's registers and stop store
    stop_t ramp_store [MAX_STOPS_DEF];
    logic [CFG_W-1:0] ramp_count;
    logic [2:0] ramp_interp;
    logic [1:0] ramp_cmode;

    logic [OUT_W-1:0] expected_colors [$];
    logic [OUT_W-1:0] want_color;
    int fail_count = 0;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    color_ramp_interpolator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // fold every later stop into the colour of stop 0
    function automatic logic [OUT_W-1:0] blend_ramp(input logic signed [POS_W-1:0] fac);
        int n;
        logic [OUT_W-1:0] acc;
        longint p0, p1, num, den;
        longint unsigned w, mix;
        logic step_form, ease_form;
        n = (ramp_count > MAX_STOPS_DEF) ? MAX_STOPS_DEF : ramp_count;
        step_form = (ramp_cmode == COLOR_RGB) && (ramp_interp == MODE_CONST);
        ease_form = (ramp_cmode == COLOR_RGB) && (ramp_interp == MODE_EASE);
        acc = ramp_store[0][STOP_W-1:POS_W];
        for (int i = 1; i < n; i++)
        begin
            p0 = ramp_store[i-1].pos;
            p1 = ramp_store[i].pos;
            if (step_form || p1 <= p0)
                w = (fac >= p1) ? ONE_Q12 : 0;
            else
            begin
                num = fac - p0;
                den = p1 - p0;
                if (num <= 0)
                    w = 0;
                else if (num >= den)
                    w = ONE_Q12;
                else
                    w = (num * ONE_Q12) / den;
                if (ease_form)
                    w = (w * w * (THREE_Q12 - 2 * w)) >> (2 * FRAC_W);
            end
            for (int k = 0; k < 4; k++)
            begin
                mix = acc[CH_W*k +: CH_W] * (ONE_Q12 - w)
                    + ramp_store[i][POS_W + CH_W*k +: CH_W] * w + HALF_Q12;
                acc[CH_W*k +: CH_W] = mix[FRAC_W +: CH_W];
            end
        end
        return acc;
    endfunction

    function automatic string channel_name(input int k);
        case (k)
            0: return "out_red";
            1: return "out_green";
            2: return "out_blue";
            default: return "out_alpha";
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("result %h arrived with none expected", m_tdata);
                fail_count++;
            end
            else
            begin
                want_color = expected_colors.pop_front();
                for (int k = 0; k < 4; k++)
                    if (m_tdata[CH_W*k +: CH_W] !== want_color[CH_W*k +: CH_W])
                    begin
                        $error("%s: expected %h, got %h", channel_name(k),
                               want_color[CH_W*k +: CH_W], m_tdata[CH_W*k +: CH_W]);
                        fail_count++;
                    end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [4:0] idx, input stop_t st,
                             input logic [POS_W-1:0] fac);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, fac, st, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_LOAD)
            ramp_store[idx] = st;
        else if (ramp_count != 0)
            expected_colors.push_back(blend_ramp(fac));
    endtask

    function automatic logic [CH_W-1:0] random_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return CH_W'($urandom);
    endfunction

    function automatic stop_t random_stop(input logic [POS_W-1:0] pos);
        stop_t st;
        st.pos   = pos;
        st.red   = random_channel();
        st.green = random_channel();
        st.blue  = random_channel();
        st.alpha = random_channel();
        return st;
    endfunction

    task automatic load_stop(input logic [4:0] idx, input stop_t st);
        send_item(OP_LOAD, idx, st, POS_W'($urandom));
    endtask

    task automatic eval_factor(input logic [POS_W-1:0] fac);
        send_item(OP_EVAL, 5'($urandom), random_stop(POS_W'($urandom)), fac);
    endtask

    // drop valid and hold until every result is back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_colors.size() != 0);
    endtask

    task automatic wait_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STOP_COUNT:  ramp_count  = val;
            REG_INTERP_MODE: ramp_interp = val[2:0];
            REG_COLOR_MODE:  ramp_cmode  = val[1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int cnt, input int interp, input int cmode);
        wait_idle();
        write_reg(REG_STOP_COUNT, CFG_W'(cnt));
        write_reg(REG_INTERP_MODE, CFG_W'(interp));
        write_reg(REG_COLOR_MODE, CFG_W'(cmode));
    endtask

    // mostly ascending positions, with some coinciding or backward steps
    task automatic load_ramp(input int kk);
        int p, base, step_max, r;
        logic scatter;
        base = -32768 + int'($urandom_range(0, 32768));
        step_max = (32767 - base) / kk;
        if (step_max < 1)
            step_max = 1;
        scatter = ($urandom_range(0, 9) == 0);
        p = base;
        for (int i = 0; i < kk; i++)
        begin
            r = $urandom_range(0, 99);
            if (scatter)
                p = int'($urandom_range(0, 65535)) - 32768;
            else if (i > 0 && r < 85)
                p += $urandom_range(1, step_max);
            else if (i > 0 && r >= 93)
                p -= $urandom_range(1, 4096);
            if (p > 32767)
                p = 32767;
            if (p < -32768)
                p = -32768;
            load_stop(5'(i), random_stop(POS_W'(p)));
        end
    endtask

    function automatic logic [POS_W-1:0] pick_factor(input int kk);
        int lo, hi, f, r;
        lo = ramp_store[0].pos;
        hi = ramp_store[kk-1].pos;
        if (lo > hi)
        begin
            f = lo;
            lo = hi;
            hi = f;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
            f = lo + int'($urandom_range(0, hi - lo));
        else if (r < 65)
            f = ramp_store[$urandom_range(0, kk - 1)].pos + int'($urandom_range(0, 2)) - 1;
        else if (r < 85)
            f = $urandom;
        else
            case ($urandom_range(0, 2))
                0: f = -32768;
                1: f = 32767;
                default: f = 0;
            endcase
        return POS_W'(f);
    endfunction

    // reset values: two stops, linear, rgb
    task automatic test_reset_config();
        load_stop(5'd0, '{alpha: '0, blue: '0, green: '0, red: '0, pos: -32768});
        load_stop(5'd1, '{alpha: '1, blue: '1, green: '1, red: '1, pos: 0});
        load_stop(5'd2, '{alpha: 16'h0001, blue: 16'h7fff, green: 16'h5678, red: 16'h1234,
                          pos: 0});
        load_stop(5'd3, '{alpha: 16'hfffe, blue: 16'h8000, green: 16'h0fff, red: 16'h8001,
                          pos: -4096});
        eval_factor(16'h8000);
        eval_factor(16'h7fff);
        eval_factor(POS_W'(-16384));
        eval_factor(16'h0000);
    endtask

    // weight forms, colour modes, coinciding and backward stops
    task automatic test_interp_forms();
        apply_config(4, MODE_LINEAR, COLOR_RGB);
        eval_factor(POS_W'(-8192));
        apply_config(4, MODE_EASE, COLOR_RGB);
        eval_factor(POS_W'(-8192));
        eval_factor(POS_W'(-30000));
        apply_config(4, MODE_CONST, COLOR_RGB);
        eval_factor(POS_W'(-1));
        eval_factor(16'h0000);
        apply_config(4, MODE_BSPLINE, COLOR_RGB);
        eval_factor(POS_W'(-20000));
        apply_config(4, MODE_CARDINAL, COLOR_RGB);
        eval_factor(POS_W'(-3000));
        apply_config(4, MODE_UNKNOWN, COLOR_RGB);
        eval_factor(POS_W'(-12000));
        apply_config(4, MODE_CONST, COLOR_HSV);
        eval_factor(POS_W'(-5000));
        apply_config(4, MODE_EASE, COLOR_HSL);
        eval_factor(POS_W'(-6000));
        apply_config(4, MODE_EASE, COLOR_UNKNOWN);
        eval_factor(POS_W'(-7000));
        // an unused register index leaves everything as it was
        wait_idle();
        write_reg(REG_UNUSED, '1);
        eval_factor(POS_W'(-9000));
        apply_config(0, MODE_LINEAR, COLOR_RGB);
        eval_factor(POS_W'(-100));
        apply_config(1, MODE_LINEAR, COLOR_RGB);
        eval_factor(POS_W'(100));
    endtask

    // full store, counts at and beyond the store size
    task automatic test_stop_count_limits();
        load_ramp(MAX_STOPS_DEF);
        apply_config(MAX_STOPS_DEF, MODE_LINEAR, COLOR_RGB);
        eval_factor(pick_factor(MAX_STOPS_DEF));
        eval_factor(pick_factor(MAX_STOPS_DEF));
        apply_config(MAX_STOPS_DEF + 1, MODE_EASE, COLOR_RGB);
        eval_factor(pick_factor(MAX_STOPS_DEF));
        apply_config(63, MODE_LINEAR, COLOR_RGB);
        eval_factor(pick_factor(MAX_STOPS_DEF));
    endtask

    task automatic test_random_ramps();
        int sent, n, kk, ev, r;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                n = $urandom_range(2, 6);
            else if (r < 85)
                n = $urandom_range(7, 16);
            else if (r < 95)
                n = $urandom_range(17, 32);
            else if (r < 98)
                n = $urandom_range(33, 63);
            else
                n = $urandom_range(0, 1);
            apply_config(n, $urandom_range(0, 7),
                         ($urandom_range(0, 99) < 60) ? COLOR_RGB
                                                     : $urandom_range(COLOR_HSV, COLOR_UNKNOWN));
            kk = (n > MAX_STOPS_DEF) ? MAX_STOPS_DEF : ((n < 2) ? 2 : n);
            load_ramp(kk);
            sent += kk;
            ev = (kk > 16) ? $urandom_range(4, 12) : $urandom_range(10, 40);
            for (int j = 0; j < ev; j++)
            begin
                if ($urandom_range(0, 99) < 8)
                    load_stop(5'($urandom_range(0, 31)), random_stop(POS_W'($urandom)));
                else
                    eval_factor(pick_factor(kk));
                sent++;
                if ($urandom_range(0, 99) < 2)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        ramp_count  = STOP_COUNT_RST;
        ramp_interp = MODE_LINEAR;
        ramp_cmode  = COLOR_RGB;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 20;
        stall_pct = 20;
        test_reset_config();
        test_interp_forms();
        test_stop_count_limits();
        test_random_ramps();

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/cri_pkg.sv
sv/cri_ram.sv
sv/cri_div.sv
sv/color_ramp_interpolator.sv
tb/tb_color_ramp_interpolator.sv
